// ----- hw/rtl/pfm_pkg.sv -----
// shared types and constants for the pulse flow meter bank
// no dependencies; imported by the divider and the top level

package pfm_pkg;

   localparam logic OP_PULSE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   localparam logic CSR_METER_COUNT = 1'b0;
   localparam logic CSR_SENSOR_MAP  = 1'b1;

   // zero interval stands for five minutes
   localparam logic [31:0] MS_DEFAULT = 32'd300000;
   // 1000 ml * 60000 ms / 450 pulses = 400000 / 3
   localparam logic [18:0] FLOW_SCALE = 19'd400000;

   localparam int NUM_W  = 53;
   localparam int DEN_W  = 35;
   localparam int QUOT_W = 33;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCESS,
      ST_START,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

// ----- hw/rtl/pfm_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
// no dependencies

module pfm_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/pfm_div.sv -----
// restoring divider, one quotient bit per cycle, saturating at 32 bits
// depends on pfm_pkg

module pfm_div
   import pfm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  numer,
   input  logic [DEN_W-1:0]  denom,
   output logic              done,
   output logic [31:0]       quot
);

   localparam int HI_W  = NUM_W - QUOT_W;
   localparam int CNT_W = $clog2(QUOT_W + 1);

   logic [DEN_W-1:0]  rem_ff;
   logic [DEN_W-1:0]  rem_in;
   logic [QUOT_W-1:0] shreg_ff;
   logic [QUOT_W-1:0] quot_ff;
   logic [DEN_W-1:0]  denom_ff;
   logic              sat_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              done_ff;
   logic [DEN_W:0]    trial;
   logic              qbit;

   always_comb begin
      trial = {rem_ff, shreg_ff[QUOT_W-1]};
      qbit  = (trial >= {1'b0, denom_ff});
      if (qbit) begin
         rem_in = DEN_W'(trial - {1'b0, denom_ff});
      end else begin
         rem_in = trial[DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= CNT_W'(QUOT_W);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         // quotient needs more than 33 bits when the top part reaches the divisor
         sat_ff   <= ({{(DEN_W - HI_W){1'b0}}, numer[NUM_W-1:QUOT_W]} >= denom);
         rem_ff   <= {{(DEN_W - HI_W){1'b0}}, numer[NUM_W-1:QUOT_W]};
         shreg_ff <= numer[QUOT_W-1:0];
         denom_ff <= denom;
         quot_ff  <= '0;
      end else if (cnt_ff != '0) begin
         rem_ff   <= rem_in;
         shreg_ff <= {shreg_ff[QUOT_W-2:0], 1'b0};
         quot_ff  <= {quot_ff[QUOT_W-2:0], qbit};
      end
   end

   assign done = done_ff;
   assign quot = (sat_ff || quot_ff[QUOT_W-1]) ? 32'hFFFF_FFFF : quot_ff[31:0];

endmodule

// ----- hw/rtl/pulse_flow_meter_bank.sv -----
// pulse flow meter bank: per-meter pulse counters with flow readout
// depends on pfm_pkg, pfm_ram and pfm_div
//
// usage
//   req channel: op pulse adds one to the counter of req_meter and gives no
//   response; op read looks up req_sensor_index among the first meter_count
//   meters of sensor_map, returns the flow in ml/min and clears that counter.
//   rsp channel: one transfer per read, rsp_found low and flow zero when no
//   meter matches.
//   csr channel: index 0 meter_count, index 1 sensor_map; always ready.
//   items are handled one at a time: a pulse reads and then writes its
//   counter, an unmatched read goes straight to the response, and a matched
//   read also runs the 33-step divider producing one quotient bit per cycle.
//   counters sit in an 8-entry ram with one valid flop per entry; reset
//   clears the valid flops, so all counters read zero right after reset.
//   a finished response waits in the output register; the next request is
//   taken meanwhile, and a following read waits only if the output register
//   is still full when its result is ready.

module pulse_flow_meter_bank
   import pfm_pkg::*;
#(
   parameter int METERS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [2:0]  req_meter,
   input  logic [7:0]  req_sensor_index,
   input  logic [31:0] req_elapsed_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic [31:0] rsp_flow_mlpm,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [63:0] csr_wdata
);

   localparam int AW = (METERS > 1) ? $clog2(METERS) : 1;

   state_type          state_ff;
   state_type          state_in;
   logic [3:0]         meter_count_ff;
   logic [63:0]        sensor_map_ff;
   logic [METERS-1:0]  valid_ff;
   logic               op_ff;
   logic [AW-1:0]      addr_ff;
   logic               found_ff;
   logic [31:0]        ms_ff;
   logic [50:0]        num_ff;
   logic [33:0]        den_ff;
   logic               rsp_valid_ff;
   logic               rsp_found_ff;
   logic [31:0]        rsp_flow_ff;

   logic               accept;
   logic               hit_any;
   logic [AW-1:0]      hit_idx;
   logic               meter_ok;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic [31:0]        wr_data;
   logic [31:0]        ram_rdata;
   logic [31:0]        cur_count;
   logic               div_start;
   logic               div_done;
   logic [31:0]        div_quot;
   logic               rsp_load;

   // first configured meter with a matching sensor number
   always_comb begin
      hit_any = 1'b0;
      hit_idx = '0;
      for (int i = METERS - 1; i >= 0; i--) begin
         if ((4'(i) < meter_count_ff) && (sensor_map_ff[8*i +: 8] == req_sensor_index)) begin
            hit_any = 1'b1;
            hit_idx = AW'(i);
         end
      end
   end

   assign meter_ok  = (32'(req_meter) < METERS);
   assign accept    = req_valid && req_ready;
   assign cur_count = valid_ff[addr_ff] ? ram_rdata : 32'd0;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = (req_op == OP_READ) ? hit_idx : req_meter[AW-1:0];
      wr_en     = 1'b0;
      wr_data   = (op_ff == OP_PULSE) ? cur_count + 32'd1 : 32'd0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               rd_en = 1'b1;
               if (req_op == OP_PULSE) begin
                  state_in = meter_ok ? ST_ACCESS : ST_IDLE;
               end else begin
                  state_in = hit_any ? ST_ACCESS : ST_DONE;
               end
            end
         end
         ST_ACCESS: begin
            wr_en    = 1'b1;
            state_in = (op_ff == OP_PULSE) ? ST_IDLE : ST_START;
         end
         ST_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         meter_count_ff <= '0;
         sensor_map_ff  <= '0;
         valid_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_METER_COUNT: meter_count_ff <= csr_wdata[3:0];
               CSR_SENSOR_MAP:  sensor_map_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (wr_en) begin
            valid_ff[addr_ff] <= 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_op;
         addr_ff  <= rd_addr;
         found_ff <= (req_op == OP_READ) && hit_any;
         ms_ff    <= (req_elapsed_ms == 32'd0) ? MS_DEFAULT : req_elapsed_ms;
      end
      if (state_ff == ST_ACCESS) begin
         num_ff <= 51'(cur_count) * 51'(FLOW_SCALE);
         den_ff <= {2'b00, ms_ff} + {1'b0, ms_ff, 1'b0};
      end
      if (rsp_load) begin
         rsp_found_ff <= found_ff;
         rsp_flow_ff  <= found_ff ? div_quot : 32'd0;
      end
   end

   pfm_ram #(
      .WIDTH (32),
      .DEPTH (METERS),
      .ADDR_W(AW)
   ) u_count_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(addr_ff),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(ram_rdata)
   );

   // rounded quotient: (2 num + den) / (2 den)
   pfm_div u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .numer({num_ff, 1'b0} + {{(NUM_W - 34){1'b0}}, den_ff}),
      .denom({den_ff, 1'b0}),
      .done (div_done),
      .quot (div_quot)
   );

   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_flow_mlpm = rsp_flow_ff;

endmodule
